// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL; included by buddy_page_allocator_top.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// Check an invariant on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ----- hdl/bpa_pkg.sv -----
// Buddy page allocator package: widths, codes, per-page info layout, helpers.
// Used by buddy_page_allocator_top.
`default_nettype none

package bpa_pkg;

	localparam int MAX_PAGES = 16384;
	localparam int ORDER_CAP = 14;

	localparam int PAGE_W  = $clog2(MAX_PAGES);      // page index
	localparam int LINK_W  = PAGE_W + 1;             // page index or nil
	localparam int CNT_W   = 15;                     // page counts
	localparam int ORDER_W = $clog2(ORDER_CAP + 2);  // order or not-a-head
	localparam int INFO_W  = ORDER_W + 1;            // {allocated, order}
	localparam int LH_N    = 2 ** ORDER_W;

	localparam logic [LINK_W-1:0]  NIL_LINK = LINK_W'(MAX_PAGES);
	localparam logic [ORDER_W-1:0] NOT_HEAD = ORDER_W'(ORDER_CAP + 1);

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OOM = 2'd1,
		ST_BAD = 2'd2
	} status_t;

	// Smallest order whose block holds n pages (n at least one)
	function automatic logic [ORDER_W-1:0] order_up(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0]   m;
		logic [ORDER_W-1:0] r;
		m = n - CNT_W'(1);
		r = '0;
		for (int j = 0; j < CNT_W; j++) begin
			if (m[j]) r = ORDER_W'(j + 1);
		end
		return r;
	endfunction

	// Order of the pool: clamp to 1..MAX_PAGES, round down to a power of two
	function automatic logic [ORDER_W-1:0] pool_order(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0]   c;
		logic [ORDER_W-1:0] r;
		c = n;
		if (c == '0) c = CNT_W'(1);
		if (c > CNT_W'(MAX_PAGES)) c = CNT_W'(MAX_PAGES);
		if (c > CNT_W'(2 ** ORDER_CAP)) c = CNT_W'(2 ** ORDER_CAP);
		r = '0;
		for (int j = 0; j < CNT_W; j++) begin
			if (c[j]) r = ORDER_W'(j);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/bpa_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing; instantiated by buddy_page_allocator_top.
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry; the read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/buddy_page_allocator_top.sv -----
// Buddy page allocator top level: command sequencer, list heads, result register.
// Depends on bpa_pkg, bpa_ram and assert_macros.svh.
`default_nettype none

// Allocates and frees power-of-two page blocks from a pool of up to 16384 pages.
// One command beat in, one result beat out. After reset, and after every write
// of pool_pages, a clearing pass over all 16384 entries rewrites the per-page info
// memory; no command beat is taken until it ends. A pool_pages write is taken
// only between commands and wins over a command beat offered in the same cycle.
// Every command runs through a sequencer around three memories with registered
// read data (next links, previous links, per-page order and allocated flag). A
// zero count, a free outside the pool or an allocation beyond the free total
// fails at once; a free that fails the block check fails after its info read;
// an allocation searches upward for a non-empty order and splits the block found
// down to the request; a free merges with free buddies, stopping at the top
// order. Each memory port takes one read and one write per memory per cycle.
// A result may sit in the output register while the next command is accepted.
module buddy_page_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // page_count[14:0], block_index[28:15]
	input  wire logic [0:0]  s_tuser,   // cmd[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // granted_index[13:0], free_total[28:14]
	output logic      [1:0]  m_tuser,   // status[1:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data
);

	localparam int PAGE_W  = bpa_pkg::PAGE_W;
	localparam int LINK_W  = bpa_pkg::LINK_W;
	localparam int CNT_W   = bpa_pkg::CNT_W;
	localparam int ORDER_W = bpa_pkg::ORDER_W;
	localparam int INFO_W  = bpa_pkg::INFO_W;
	localparam int LH_N    = bpa_pkg::LH_N;

	typedef enum logic [18:0] {
		S_IDLE   = 19'b0000000000000000001,
		S_START  = 19'b0000000000000000010,
		S_SEARCH = 19'b0000000000000000100,
		S_SP_RD  = 19'b0000000000000001000,
		S_SP_UNL = 19'b0000000000000010000,
		S_SP_WR  = 19'b0000000000000100000,
		S_SP_FIN = 19'b0000000000001000000,
		S_TK_RD  = 19'b0000000000010000000,
		S_TK_UNL = 19'b0000000000100000000,
		S_F_RD   = 19'b0000000001000000000,
		S_F_CHK  = 19'b0000000010000000000,
		S_F_PUSH = 19'b0000000100000000000,
		S_M_RD   = 19'b0000001000000000000,
		S_M_TEST = 19'b0000010000000000000,
		S_U_RD   = 19'b0000100000000000000,
		S_U_WR   = 19'b0001000000000000000,
		S_J_WR1  = 19'b0010000000000000000,
		S_J_WR2  = 19'b0100000000000000000,
		S_DONE   = 19'b1000000000000000000
	} state_t;

	state_t               state_q;
	logic                 clr_q;
	logic [CNT_W-1:0]     clr_addr_q;
	logic [ORDER_W-1:0]   top_q;
	logic [CNT_W-1:0]     free_q;
	logic [LINK_W-1:0]    lh_q [LH_N];

	bpa_pkg::cmd_t        cmd_q;
	logic [CNT_W-1:0]     count_q;
	logic [PAGE_W-1:0]    base_q;
	logic [ORDER_W-1:0]   k_q;
	logic [ORDER_W-1:0]   i_q;
	logic [PAGE_W-1:0]    a_q;
	logic [PAGE_W-1:0]    b_q;
	logic [PAGE_W-1:0]    left_q;
	logic [PAGE_W-1:0]    buddy_q;
	logic                 second_q;
	bpa_pkg::status_t     res_status_q;
	logic [PAGE_W-1:0]    res_granted_q;

	logic                 out_valid_q;
	bpa_pkg::status_t     out_status_q;
	logic [PAGE_W-1:0]    out_granted_q;
	logic [CNT_W-1:0]     out_free_q;

	// Memory ports
	logic                 next_we, prev_we, info_we;
	logic [PAGE_W-1:0]    next_wa, prev_wa, info_wa;
	logic [LINK_W-1:0]    next_wd, prev_wd;
	logic [INFO_W-1:0]    info_wd;
	logic [PAGE_W-1:0]    next_ra, prev_ra, info_ra;
	logic [LINK_W-1:0]    next_rd, prev_rd;
	logic [INFO_W-1:0]    info_rd;

	logic [LINK_W-1:0]    cur_head, k_head, up_head;
	logic [ORDER_W-1:0]   k_up;
	logic [PAGE_W-1:0]    node, buddy_addr, split_b;
	logic [CNT_W-1:0]     pool_size, k_pages, ho_pages;
	logic [ORDER_W-1:0]   rd_order;
	logic                 rd_alloc;
	logic [ORDER_W-1:0]   cfg_top;
	logic                 s_fire, cfg_fire;

	assign s_tready  = (state_q == S_IDLE) && !clr_q && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_top   = bpa_pkg::pool_order(cfg_data);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_free_q, out_granted_q};

	assign cur_head   = lh_q[i_q];
	assign k_head     = lh_q[k_q];
	assign k_up       = k_q + ORDER_W'(1);
	assign up_head    = lh_q[k_up];
	assign node       = second_q ? buddy_q : left_q;
	assign buddy_addr = left_q ^ (PAGE_W'(1) << k_q);
	assign split_b    = a_q + (PAGE_W'(1) << (i_q - ORDER_W'(1)));
	assign pool_size  = CNT_W'(1) << top_q;
	assign k_pages    = CNT_W'(1) << k_q;
	assign rd_order   = info_rd[ORDER_W-1:0];
	assign rd_alloc   = info_rd[INFO_W-1];
	assign ho_pages   = CNT_W'(1) << rd_order;

	bpa_ram #(.WIDTH(LINK_W), .DEPTH(bpa_pkg::MAX_PAGES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(next_ra), .rdata(next_rd)
	);

	bpa_ram #(.WIDTH(LINK_W), .DEPTH(bpa_pkg::MAX_PAGES)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(prev_ra), .rdata(prev_rd)
	);

	bpa_ram #(.WIDTH(INFO_W), .DEPTH(bpa_pkg::MAX_PAGES)) u_info (
		.clk(clk), .we(info_we), .waddr(info_wa), .wdata(info_wd),
		.raddr(info_ra), .rdata(info_rd)
	);

	// Drive memory ports from the clearing pass or the sequencer
	always_comb begin
		next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_ra = '0;
		info_we = 1'b0; info_wa = '0; info_wd = '0; info_ra = '0;
		if (clr_q) begin
			info_we = 1'b1;
			info_wa = clr_addr_q[PAGE_W-1:0];
			if (clr_addr_q == '0) begin
				info_wd = {1'b0, top_q};
				next_we = 1'b1;
				next_wd = bpa_pkg::NIL_LINK;
				prev_we = 1'b1;
				prev_wd = bpa_pkg::NIL_LINK;
			end else begin
				info_wd = {1'b0, bpa_pkg::NOT_HEAD};
			end
		end else begin
			unique case (state_q)
				S_SP_RD: begin
					next_ra = cur_head[PAGE_W-1:0];
				end
				S_SP_UNL: begin
					if (next_rd != bpa_pkg::NIL_LINK) begin
						prev_we = 1'b1;
						prev_wa = next_rd[PAGE_W-1:0];
						prev_wd = bpa_pkg::NIL_LINK;
					end
					info_we = 1'b1;
					info_wa = a_q;
					info_wd = {1'b0, i_q - ORDER_W'(1)};
					next_we = 1'b1;
					next_wa = a_q;
					next_wd = {1'b0, split_b};
				end
				S_SP_WR: begin
					info_we = 1'b1;
					info_wa = b_q;
					info_wd = {1'b0, i_q - ORDER_W'(1)};
					prev_we = 1'b1;
					prev_wa = a_q;
					prev_wd = bpa_pkg::NIL_LINK;
					next_we = 1'b1;
					next_wa = b_q;
					next_wd = bpa_pkg::NIL_LINK;
				end
				S_SP_FIN: begin
					prev_we = 1'b1;
					prev_wa = b_q;
					prev_wd = {1'b0, a_q};
				end
				S_TK_RD: begin
					next_ra = k_head[PAGE_W-1:0];
				end
				S_TK_UNL: begin
					if (next_rd != bpa_pkg::NIL_LINK) begin
						prev_we = 1'b1;
						prev_wa = next_rd[PAGE_W-1:0];
						prev_wd = bpa_pkg::NIL_LINK;
					end
					info_we = 1'b1;
					info_wa = a_q;
					info_wd = {1'b1, k_q};
				end
				S_F_RD: begin
					info_ra = base_q;
				end
				S_F_CHK: begin
					if (rd_order <= top_q && rd_alloc
							&& bpa_pkg::order_up(count_q) == rd_order) begin
						info_we = 1'b1;
						info_wa = base_q;
						info_wd = {1'b0, rd_order};
						next_we = 1'b1;
						next_wa = base_q;
						next_wd = lh_q[rd_order];
						prev_we = 1'b1;
						prev_wa = base_q;
						prev_wd = bpa_pkg::NIL_LINK;
					end
				end
				S_F_PUSH: begin
					if (k_head != bpa_pkg::NIL_LINK) begin
						prev_we = 1'b1;
						prev_wa = k_head[PAGE_W-1:0];
						prev_wd = {1'b0, left_q};
					end
				end
				S_M_RD: begin
					info_ra = buddy_addr;
				end
				S_U_RD: begin
					next_ra = node;
					prev_ra = node;
				end
				S_U_WR: begin
					if (prev_rd != bpa_pkg::NIL_LINK) begin
						next_we = 1'b1;
						next_wa = prev_rd[PAGE_W-1:0];
						next_wd = next_rd;
					end
					if (next_rd != bpa_pkg::NIL_LINK) begin
						prev_we = 1'b1;
						prev_wa = next_rd[PAGE_W-1:0];
						prev_wd = prev_rd;
					end
				end
				S_J_WR1: begin
					info_we = 1'b1;
					info_wa = buddy_q;
					info_wd = {1'b0, bpa_pkg::NOT_HEAD};
					next_we = 1'b1;
					next_wa = left_q;
					next_wd = up_head;
					prev_we = 1'b1;
					prev_wa = left_q;
					prev_wd = bpa_pkg::NIL_LINK;
				end
				S_J_WR2: begin
					info_we = 1'b1;
					info_wa = left_q;
					info_wd = {1'b0, k_up};
					if (up_head != bpa_pkg::NIL_LINK) begin
						prev_we = 1'b1;
						prev_wa = up_head[PAGE_W-1:0];
						prev_wd = {1'b0, left_q};
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the command in flight
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q   <= bpa_pkg::cmd_t'(s_tuser[0]);
			count_q <= s_tdata[14:0];
			base_q  <= s_tdata[28:15];
			k_q     <= bpa_pkg::order_up(s_tdata[14:0]);
		end else begin
			unique case (state_q)
				S_F_CHK: k_q <= rd_order;
				S_J_WR2: k_q <= k_up;
				default: ;
			endcase
		end
		unique case (state_q)
			S_SP_RD:  a_q <= cur_head[PAGE_W-1:0];
			S_TK_RD:  a_q <= k_head[PAGE_W-1:0];
			default: ;
		endcase
		if (state_q == S_SP_UNL) b_q <= split_b;
		if (state_q == S_F_CHK) left_q <= base_q;
		if (state_q == S_M_TEST) begin
			if (buddy_addr < left_q) begin
				left_q  <= buddy_addr;
				buddy_q <= left_q;
			end else begin
				buddy_q <= buddy_addr;
			end
		end
	end

	// Sequencer, list heads, pool state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			clr_q         <= 1'b1;
			clr_addr_q    <= '0;
			top_q         <= bpa_pkg::pool_order(CNT_W'(bpa_pkg::MAX_PAGES));
			free_q        <= CNT_W'(1) << bpa_pkg::pool_order(CNT_W'(bpa_pkg::MAX_PAGES));
			for (int j = 0; j < LH_N; j++) begin
				lh_q[j] <= (ORDER_W'(j) == bpa_pkg::pool_order(CNT_W'(bpa_pkg::MAX_PAGES)))
					? '0 : bpa_pkg::NIL_LINK;
			end
			i_q           <= '0;
			second_q      <= 1'b0;
			res_status_q  <= bpa_pkg::ST_OK;
			res_granted_q <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= bpa_pkg::ST_OK;
			out_granted_q <= '0;
			out_free_q    <= '0;
		end else begin
			// Drop the result beat once taken, unless a new one loads now
			if (out_valid_q && m_tready && state_q != S_DONE) out_valid_q <= 1'b0;

			// Restart or advance the clearing pass
			if (cfg_fire) begin
				clr_q      <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_q) begin
				if (clr_addr_q == CNT_W'(bpa_pkg::MAX_PAGES - 1)) clr_q <= 1'b0;
				clr_addr_q <= clr_addr_q + CNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_fire) state_q <= S_START;
				end
				S_START: begin
					res_granted_q <= '0;
					if (count_q == '0) begin
						res_status_q <= bpa_pkg::ST_BAD;
						state_q      <= S_DONE;
					end else if (cmd_q == bpa_pkg::CMD_ALLOC) begin
						if (count_q > free_q || k_q > top_q) begin
							res_status_q <= bpa_pkg::ST_OOM;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= bpa_pkg::ST_OK;
							i_q          <= k_q;
							state_q      <= S_SEARCH;
						end
					end else if ({1'b0, base_q} >= pool_size) begin
						res_status_q <= bpa_pkg::ST_BAD;
						state_q      <= S_DONE;
					end else begin
						res_status_q <= bpa_pkg::ST_OK;
						state_q      <= S_F_RD;
					end
				end
				// Find the smallest non-empty order at or above the request
				S_SEARCH: begin
					if (i_q > top_q) begin
						res_status_q <= bpa_pkg::ST_OOM;
						state_q      <= S_DONE;
					end else if (cur_head != bpa_pkg::NIL_LINK) begin
						state_q <= (i_q == k_q) ? S_TK_RD : S_SP_RD;
					end else begin
						i_q <= i_q + ORDER_W'(1);
					end
				end
				S_SP_RD:  state_q <= S_SP_UNL;
				S_SP_UNL: begin
					lh_q[i_q] <= next_rd;
					state_q   <= S_SP_WR;
				end
				S_SP_WR: begin
					lh_q[i_q - ORDER_W'(1)] <= {1'b0, a_q};
					state_q <= S_SP_FIN;
				end
				S_SP_FIN: begin
					i_q     <= i_q - ORDER_W'(1);
					state_q <= (i_q - ORDER_W'(1) == k_q) ? S_TK_RD : S_SP_RD;
				end
				S_TK_RD:  state_q <= S_TK_UNL;
				S_TK_UNL: begin
					lh_q[k_q]     <= next_rd;
					free_q        <= free_q - k_pages;
					res_granted_q <= a_q;
					state_q       <= S_DONE;
				end
				S_F_RD:   state_q <= S_F_CHK;
				S_F_CHK: begin
					if (rd_order <= top_q && rd_alloc
							&& bpa_pkg::order_up(count_q) == rd_order) begin
						free_q  <= free_q + ho_pages;
						state_q <= S_F_PUSH;
					end else begin
						res_status_q <= bpa_pkg::ST_BAD;
						state_q      <= S_DONE;
					end
				end
				S_F_PUSH: begin
					lh_q[k_q] <= {1'b0, left_q};
					state_q   <= S_M_RD;
				end
				// Merge with a free buddy of equal order while below the top
				S_M_RD: begin
					state_q <= (k_q >= top_q) ? S_DONE : S_M_TEST;
				end
				S_M_TEST: begin
					if (rd_alloc || rd_order != k_q) begin
						state_q <= S_DONE;
					end else begin
						second_q <= 1'b0;
						state_q  <= S_U_RD;
					end
				end
				S_U_RD:   state_q <= S_U_WR;
				S_U_WR: begin
					if (prev_rd == bpa_pkg::NIL_LINK) lh_q[k_q] <= next_rd;
					second_q <= 1'b1;
					state_q  <= second_q ? S_J_WR1 : S_U_RD;
				end
				S_J_WR1:  state_q <= S_J_WR2;
				S_J_WR2: begin
					lh_q[k_up] <= {1'b0, left_q};
					state_q    <= S_M_RD;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= res_status_q;
						out_granted_q <= res_granted_q;
						out_free_q    <= free_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// Re-initialize the pool on a register write (only taken when idle)
			if (cfg_fire) begin
				top_q  <= cfg_top;
				free_q <= CNT_W'(1) << cfg_top;
				for (int j = 0; j < LH_N; j++) begin
					lh_q[j] <= (ORDER_W'(j) == cfg_top) ? '0 : bpa_pkg::NIL_LINK;
				end
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_IMPL(a_no_beat_while_clearing, s_tready, !clr_q, "command taken while clearing")
	`ASSERT_IMPL(a_grant_zero, m_tvalid && m_tuser != bpa_pkg::ST_OK, m_tdata[13:0] == '0, "grant on failure")
	`ASSERT_ALWAYS(a_free_within_pool, free_q <= pool_size, "free page total exceeds pool")

endmodule

`default_nettype wire
